@@ rtl/core/hb64_pkg.sv @@
// ----------------------------------------------------------------------------
// hb64_pkg
// Types, constants and character functions shared by the hex-to-base64 blocks.
// ----------------------------------------------------------------------------
package hb64_pkg;

	localparam int GROUP_W   = 24;
	localparam int NIBBLE_W  = 4;
	localparam int SEXTET_W  = 6;
	localparam int COUNT_W   = 3;
	localparam int MAX_CHARS = 5;
	localparam int GROUP_SEXTETS = 4;

	localparam logic [COUNT_W-1:0] FULL_DIGITS = 3'd5;
	localparam logic [COUNT_W-1:0] DONE_DIGITS = 3'd6;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef logic [7:0] char_t;

	typedef struct packed {
		char_t [MAX_CHARS-1:0]  chars;
		logic  [COUNT_W-1:0]    count;
	} hb64_bundle_t;

	typedef struct packed {
		logic                ok;
		logic [NIBBLE_W-1:0] nibble;
	} hex_digit_t;

	// Hex digit of either case.
	function automatic hex_digit_t hex_decode(input char_t c);
		hex_digit_t r;
		r.ok     = 1'b0;
		r.nibble = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.ok     = 1'b1;
			r.nibble = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.ok     = 1'b1;
			r.nibble = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.ok     = 1'b1;
			r.nibble = 4'(c - 8'h57);
		end
		return r;
	endfunction

	// Base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
	function automatic char_t b64_char(input logic [SEXTET_W-1:0] s);
		char_t v;
		char_t r;
		v = {2'b00, s};
		if (s < 6'd26)
			r = v + 8'h41;
		else if (s < 6'd52)
			r = v + 8'h47;
		else if (s < 6'd62)
			r = v - 8'h04;
		else if (s == 6'd62)
			r = 8'h2B;
		else
			r = 8'h2F;
		return r;
	endfunction

	// Base64 symbols that carry data for a group of n hex digits.
	function automatic logic [COUNT_W-1:0] sextets_for_digits(input logic [COUNT_W-1:0] n);
		logic [COUNT_W-1:0] r;
		case (n)
			3'd0:    r = 3'd0;
			3'd1:    r = 3'd1;
			3'd2:    r = 3'd2;
			3'd3:    r = 3'd2;
			3'd4:    r = 3'd3;
			default: r = 3'd4;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/hb64_packer.sv @@
// ----------------------------------------------------------------------------
// hb64_packer
// Registers each input character, gathers hex digits into a 24-bit group and
// builds the set of output characters that the character causes.
// ----------------------------------------------------------------------------
module hb64_packer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hb64_pkg::char_t       symbol,
	input  logic                  end_of_stream,
	input  logic                  sym_valid,
	output logic                  sym_stall,
	input  logic                  drain_free,
	output logic                  bundle_load,
	output hb64_pkg::hb64_bundle_t bundle
);
	import hb64_pkg::*;

	logic                 valid_s1;
	char_t                symbol_s1;
	logic                 eos_s1;

	logic [GROUP_W-1:0]   group_q;
	logic [COUNT_W-1:0]   digits_q;

	logic [COUNT_W-1:0]   n;
	hex_digit_t           dec;
	logic                 is_hex;
	logic                 full;
	logic                 flushing;
	logic                 echo;
	logic [4:0]           shamt;
	logic [GROUP_W-1:0]   new_group;
	logic [GROUP_W-1:0]   flush_bits;
	logic [COUNT_W-1:0]   flush_n;
	logic [COUNT_W-1:0]   emit;
	logic                 advance;

	always_comb begin
		n          = (digits_q > FULL_DIGITS) ? FULL_DIGITS : digits_q;
		dec        = hex_decode(symbol_s1);
		is_hex     = dec.ok && !eos_s1;
		echo       = !eos_s1 && !dec.ok;
		shamt      = {FULL_DIGITS - n, 2'b00};
		new_group  = group_q | ({{(GROUP_W-NIBBLE_W){1'b0}}, dec.nibble} << shamt);
		full       = is_hex && (n == FULL_DIGITS);
		flushing   = !is_hex || full;
		flush_n    = full ? DONE_DIGITS : n;
		flush_bits = full ? new_group : group_q;
		emit       = sextets_for_digits(flush_n);

		bundle.chars = {MAX_CHARS{symbol_s1}};
		if (flush_n != '0) begin
			for (int i = 0; i < GROUP_SEXTETS; i++) begin
				if (3'(i) < emit)
					bundle.chars[i] = b64_char(flush_bits[GROUP_W-1-SEXTET_W*i -: SEXTET_W]);
				else
					bundle.chars[i] = PAD_CHAR;
			end
		end

		if (!flushing)
			bundle.count = 3'd0;
		else if (flush_n != '0)
			bundle.count = echo ? 3'd5 : 3'd4;
		else
			bundle.count = echo ? 3'd1 : 3'd0;
	end

	// An item that causes no output moves on even while the drain is busy.
	assign advance     = valid_s1 && ((bundle.count == '0) || drain_free);
	assign bundle_load = advance && (bundle.count != '0);
	assign sym_stall   = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			group_q  <= '0;
			digits_q <= '0;
		end else begin
			if (!valid_s1 || advance) begin
				valid_s1 <= sym_valid;
			end
			if (advance) begin
				if (flushing) begin
					group_q  <= '0;
					digits_q <= '0;
				end else begin
					group_q  <= new_group;
					digits_q <= n + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sym_valid && !sym_stall) begin
			symbol_s1 <= symbol;
			eos_s1    <= end_of_stream;
		end
	end

endmodule

@@ rtl/core/hb64_drain.sv @@
// ----------------------------------------------------------------------------
// hb64_drain
// Holds the characters of one input item and hands them out one per transfer.
// ----------------------------------------------------------------------------
module hb64_drain (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   bundle_load,
	input  hb64_pkg::hb64_bundle_t bundle,
	output logic                   drain_free,
	output hb64_pkg::char_t        out_char,
	output logic                   last,
	output logic                   char_valid,
	input  logic                   char_stall
);
	import hb64_pkg::*;

	char_t [MAX_CHARS-1:0] chars_q;
	logic  [COUNT_W-1:0]   left_q;
	logic                  xfer;

	assign char_valid = (left_q != '0);
	assign out_char   = chars_q[0];
	assign last       = (left_q == 3'd1);
	assign xfer       = char_valid && !char_stall;
	// Free when empty, or once the final character goes out in this cycle.
	assign drain_free = !char_valid || (last && !char_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (bundle_load) begin
			left_q <= bundle.count;
		end else if (xfer) begin
			left_q <= left_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (bundle_load) begin
			chars_q <= bundle.chars;
		end else if (xfer) begin
			for (int i = 0; i < MAX_CHARS - 1; i++)
				chars_q[i] <= chars_q[i+1];
		end
	end

endmodule

@@ rtl/core/hex_text_to_base64_encoder.sv @@
// ----------------------------------------------------------------------------
// hex_text_to_base64_encoder
// Turns a stream of hex text into base64, echoing other characters.
// ----------------------------------------------------------------------------
// Input channel: symbol and end_of_stream, with sym_valid and sym_stall.
// Hex digits are packed six to a group; a full group gives four base64
// characters, and a non-hex character or end_of_stream flushes a partial group
// with '=' padding. A non-hex character is then echoed.
// Output channel: out_char and last, with char_valid and char_stall. last
// marks the final character caused by one input item.
// An accepted item is held in the input register; once the output shift
// register is free, its characters are loaded there and the first is offered.
// Items that give no output (hex digits before the sixth) are taken one per
// cycle while no earlier item waits on the output shift register. An item that
// gives characters holds that register until its last one is transferred, and
// the input register takes the next item meanwhile.
// When the receiver stalls, the output holds and the input stalls as soon as
// the input register is waiting on the output shift register.
// Reset clears the digit group, the digit count and both valid flags.
// ----------------------------------------------------------------------------
module hex_text_to_base64_encoder (
	input  logic            clk,
	input  logic            arst_n,
	input  hb64_pkg::char_t symbol,
	input  logic            end_of_stream,
	input  logic            sym_valid,
	output logic            sym_stall,
	output hb64_pkg::char_t out_char,
	output logic            last,
	output logic            char_valid,
	input  logic            char_stall
);
	import hb64_pkg::*;

	hb64_bundle_t bundle;
	logic         bundle_load;
	logic         drain_free;

	hb64_packer u_packer (
		.clk           (clk),
		.arst_n        (arst_n),
		.symbol        (symbol),
		.end_of_stream (end_of_stream),
		.sym_valid     (sym_valid),
		.sym_stall     (sym_stall),
		.drain_free    (drain_free),
		.bundle_load   (bundle_load),
		.bundle        (bundle)
	);

	hb64_drain u_drain (
		.clk         (clk),
		.arst_n      (arst_n),
		.bundle_load (bundle_load),
		.bundle      (bundle),
		.drain_free  (drain_free),
		.out_char    (out_char),
		.last        (last),
		.char_valid  (char_valid),
		.char_stall  (char_stall)
	);

	// A new set of characters never overwrites one still being sent.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		bundle_load |-> drain_free)
		else $error("character set loaded while output busy");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		bundle_load |-> (bundle.count != 3'd0 && bundle.count <= 3'd5))
		else $error("character set count out of range");

	// The output shows the loaded set on the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		bundle_load |=> char_valid && (last == (($past(bundle.count)) == 3'd1)))
		else $error("loaded characters not presented");

endmodule
